/* src/dmap_pkg.sv */
// Shared types and constants for the depth-to-RGB565 colormap block.
`timescale 1ns / 1ps

package dmap_pkg;

  localparam int DEPTH_W = 16;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 16;
  localparam int X_W     = 11;   // offset inside a segment, largest is 1999
  localparam int BASE_W  = 12;   // stop positions below the saturation point
  localparam int RECIP_W = 21;
  localparam int PROD_W  = X_W + RECIP_W;
  localparam int QUO_LSB = 20;

  // gradient stops (millimetres)
  localparam logic [DEPTH_W-1:0] STOP_RED    = 16'd200;
  localparam logic [DEPTH_W-1:0] STOP_ORANGE = 16'd500;
  localparam logic [DEPTH_W-1:0] STOP_YELLOW = 16'd1000;
  localparam logic [DEPTH_W-1:0] STOP_GREEN  = 16'd2000;
  localparam logic [DEPTH_W-1:0] DEPTH_SAT   = 16'd4000;

  localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;
  localparam logic [CHAN_W-1:0] ORANGE_GRN = 8'd165;

  // per-segment slope k/w in lowest terms, as a ceiling reciprocal scaled by 2^QUO_LSB;
  // 2^20 exceeds x_max * denominator on every segment, so floor(x*C >> 20) is exact
  localparam int SCALE = 1 << QUO_LSB;
  localparam logic [RECIP_W-1:0] RECIP_S0 = RECIP_W'((51 * SCALE + 39) / 40);
  localparam logic [RECIP_W-1:0] RECIP_S1 = RECIP_W'((11 * SCALE + 19) / 20);
  localparam logic [RECIP_W-1:0] RECIP_S2 = RECIP_W'((9 * SCALE + 49) / 50);
  localparam logic [RECIP_W-1:0] RECIP_S3 = RECIP_W'((51 * SCALE + 199) / 200);
  localparam logic [RECIP_W-1:0] RECIP_S4 = RECIP_W'((51 * SCALE + 399) / 400);

  // segment codes
  localparam logic [2:0] SEG_BLK_RED = 3'd0;
  localparam logic [2:0] SEG_RED_ORG = 3'd1;
  localparam logic [2:0] SEG_ORG_YEL = 3'd2;
  localparam logic [2:0] SEG_YEL_GRN = 3'd3;
  localparam logic [2:0] SEG_GRN_BLU = 3'd4;

  typedef struct packed {
    logic       zero;    // depth is zero: black
    logic       sat;     // depth at or beyond the far stop: blue
    logic [2:0] seg;
    logic       exact;   // k*x divides evenly by w (falling channels only)
  } seg_info_t;

endpackage

/* src/dmap_seg.sv */
// Segment decode and scaled slope product for one depth sample.
`timescale 1ns / 1ps

module dmap_seg (
  input  logic [dmap_pkg::DEPTH_W-1:0] depth,
  output dmap_pkg::seg_info_t          info,
  output logic [dmap_pkg::CHAN_W-1:0]  quo
);
  import dmap_pkg::*;

  logic [BASE_W-1:0]  base;
  logic [BASE_W-1:0]  x_full;
  logic [X_W-1:0]     x;
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    info.zero  = (depth == '0);
    info.sat   = (depth >= DEPTH_SAT);
    info.seg   = SEG_GRN_BLU;
    info.exact = 1'b0;
    if (depth <= STOP_RED) begin
      info.seg = SEG_BLK_RED;
    end else if (depth <= STOP_ORANGE) begin
      info.seg = SEG_RED_ORG;
    end else if (depth <= STOP_YELLOW) begin
      info.seg = SEG_ORG_YEL;
    end else if (depth <= STOP_GREEN) begin
      info.seg = SEG_YEL_GRN;
    end

    case (info.seg)
      SEG_BLK_RED: begin
        base  = '0;
        recip = RECIP_S0;
      end
      SEG_RED_ORG: begin
        base  = STOP_RED[BASE_W-1:0];
        recip = RECIP_S1;
      end
      SEG_ORG_YEL: begin
        base  = STOP_ORANGE[BASE_W-1:0];
        recip = RECIP_S2;
      end
      SEG_YEL_GRN: begin
        base  = STOP_YELLOW[BASE_W-1:0];
        recip = RECIP_S3;
      end
      default: begin
        base  = STOP_GREEN[BASE_W-1:0];
        recip = RECIP_S4;
      end
    endcase

    // only meaningful below saturation, where depth fits in BASE_W bits
    x_full = depth[BASE_W-1:0] - base;
    x      = x_full[X_W-1:0];

    // 255*x/1000 is whole iff x is a multiple of 200; 255*x/2000 iff a multiple of 400
    if (info.seg == SEG_YEL_GRN) begin
      info.exact = x inside {11'd200, 11'd400, 11'd600, 11'd800, 11'd1000};
    end else if (info.seg == SEG_GRN_BLU) begin
      info.exact = x inside {11'd400, 11'd800, 11'd1200, 11'd1600};
    end

    prod = {{RECIP_W{1'b0}}, x} * {{X_W{1'b0}}, recip};
    quo  = prod[QUO_LSB +: CHAN_W];
  end

endmodule

/* src/dmap_mix.sv */
// Channel assembly from segment and quotient, plus RGB565 packing.
`timescale 1ns / 1ps

module dmap_mix (
  input  dmap_pkg::seg_info_t          info,
  input  logic [dmap_pkg::CHAN_W-1:0]  quo,
  output logic [dmap_pkg::CHAN_W-1:0]  red,
  output logic [dmap_pkg::CHAN_W-1:0]  green,
  output logic [dmap_pkg::CHAN_W-1:0]  blue,
  output logic [dmap_pkg::COLOR_W-1:0] color
);
  import dmap_pkg::*;

  logic [CHAN_W-1:0] fall;   // 255 - ceil(k*x/w)

  always_comb begin
    fall  = CHAN_MAX - quo - {{(CHAN_W-1){1'b0}}, ~info.exact};
    red   = '0;
    green = '0;
    blue  = '0;
    if (info.zero) begin
      red = '0;
    end else if (info.sat) begin
      blue = CHAN_MAX;
    end else begin
      case (info.seg)
        SEG_BLK_RED: begin
          red = quo;
        end
        SEG_RED_ORG: begin
          red   = CHAN_MAX;
          green = quo;
        end
        SEG_ORG_YEL: begin
          red   = CHAN_MAX;
          green = ORANGE_GRN + quo;
        end
        SEG_YEL_GRN: begin
          red   = fall;
          green = CHAN_MAX;
        end
        default: begin
          green = fall;
          blue  = quo;
        end
      endcase
    end
    color = {red[7:3], green[7:2], blue[7:3]};
  end

endmodule

/* src/depth_to_rgb565_colormap_core.sv */
// Top level of the depth-to-RGB565 heatmap colormap stream block.
`timescale 1ns / 1ps

// Maps each 16-bit depth sample (mm) to a heatmap color over the stops black 0, red 200,
// orange 500, yellow 1000, green 2000, blue 4000; zero is black, 4000 and up is blue.
// One transaction in per clock and one result out per clock when the output is not
// stalled. A sample accepted into the input register passes once through segment
// decode, one 11x21 constant-reciprocal multiply and channel select, and is written
// into the output register when the output is not stalled, which raises out_tvalid.
// While a result waits on out_tready the input register can still take one more
// sample; after that in_tready stays low until the result leaves.
module depth_to_rgb565_colormap_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dmap_pkg::DEPTH_W-1:0]  in_tdata,   // [15:0] depth
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata   // [15:0] color_rgb565, [23:16] red_level,
                                                    // [31:24] green_level, [39:32] blue_level
);
  import dmap_pkg::*;

  logic                in_valid_r;
  logic                in_valid_nxt;
  logic [DEPTH_W-1:0]  depth_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [39:0]         out_data_r;
  logic                stall;
  logic                in_fire;
  logic                adv;

  seg_info_t           info;
  logic [CHAN_W-1:0]   quo;
  logic [CHAN_W-1:0]   red;
  logic [CHAN_W-1:0]   green;
  logic [CHAN_W-1:0]   blue;
  logic [COLOR_W-1:0]  color;

  dmap_seg u_seg (
    .depth (depth_r),
    .info  (info),
    .quo   (quo)
  );

  dmap_mix u_mix (
    .info  (info),
    .quo   (quo),
    .red   (red),
    .green (green),
    .blue  (blue),
    .color (color)
  );

  assign stall     = out_valid_r && !out_tready;
  assign adv       = in_valid_r && !stall;
  assign in_tready = !in_valid_r || !stall;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    out_valid_nxt = out_valid_r;
    if (!stall) begin
      out_valid_nxt = in_valid_r;
    end
    if (in_tready) begin
      in_valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      depth_r <= in_tdata;
    end
    if (adv) begin
      out_data_r <= {blue, green, red, color};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_far_is_blue: assert property (@(posedge clk) disable iff (!rst_n)
    adv && depth_r >= DEPTH_SAT |=> out_tdata == {8'd255, 8'd0, 8'd0, 16'h001F})
    else $error("far depth did not give blue");

  a_zero_is_black: assert property (@(posedge clk) disable iff (!rst_n)
    adv && depth_r == '0 |=> out_tdata == '0)
    else $error("zero depth did not give black");

  a_stop_yellow: assert property (@(posedge clk) disable iff (!rst_n)
    adv && depth_r == STOP_YELLOW |=> out_tdata[39:16] == {8'd0, 8'd255, 8'd255})
    else $error("yellow stop color wrong");

  a_adv_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_tvalid)
    else $error("advanced transaction did not reach the output");

  a_pack: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:0] == {out_tdata[23:19], out_tdata[31:26], out_tdata[39:35]})
    else $error("rgb565 packing disagrees with channels");

endmodule

/* tb/colormap_checker.sv */
// Scoreboard for the depth colormap stream: predicts each heatmap color and compares.
`timescale 1ns / 1ps

module colormap_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [dmap_pkg::DEPTH_W-1:0]  in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [39:0]                   out_tdata,
  output int                            mismatches,
  output int                            outstanding
);

  // matches the out_tdata layout, most significant field first
  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] rgb565;
  } heat_color_t;

  localparam int FAR_MM = 4000;

  heat_color_t expected_colors[$];

  function automatic logic [7:0] lerp_level(input int from_lvl, input int to_lvl,
                                            input int x, input int w);
    return 8'((from_lvl * (w - x) + to_lvl * x) / w);
  endfunction

  function automatic heat_color_t heat_color(input logic [15:0] depth);
    heat_color_t c;
    int d0, w, x;
    int ra, ga, ba, rb, gb, bb;
    c = '0;
    if (depth == 16'd0) begin
      c = '0;
    end else if (int'(depth) >= FAR_MM) begin
      c.blue = 8'd255;
    end else begin
      // a depth sitting on a stop belongs to the segment ending there
      if (depth <= 16'd200) begin
        d0 = 0;    w = 200;  ra = 0;   ga = 0;   ba = 0;   rb = 255; gb = 0;   bb = 0;
      end else if (depth <= 16'd500) begin
        d0 = 200;  w = 300;  ra = 255; ga = 0;   ba = 0;   rb = 255; gb = 165; bb = 0;
      end else if (depth <= 16'd1000) begin
        d0 = 500;  w = 500;  ra = 255; ga = 165; ba = 0;   rb = 255; gb = 255; bb = 0;
      end else if (depth <= 16'd2000) begin
        d0 = 1000; w = 1000; ra = 255; ga = 255; ba = 0;   rb = 0;   gb = 255; bb = 0;
      end else begin
        d0 = 2000; w = 2000; ra = 0;   ga = 255; ba = 0;   rb = 0;   gb = 0;   bb = 255;
      end
      x = int'(depth) - d0;
      c.red   = lerp_level(ra, rb, x, w);
      c.green = lerp_level(ga, gb, x, w);
      c.blue  = lerp_level(ba, bb, x, w);
    end
    c.rgb565 = {c.red[7:3], c.green[7:2], c.blue[7:3]};
    return c;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
               $time, field, want, want, got, got);
    end
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    heat_color_t want, got;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_colors.push_back(heat_color(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_colors.size() == 0) begin
          mismatches++;
          $display("%0t ns: result transaction with nothing expected, actual 0x%010h",
                   $time, out_tdata);
        end else begin
          want = expected_colors.pop_front();
          check_field("color_rgb565", want.rgb565, got.rgb565);
          check_field("red_level", want.red, got.red);
          check_field("green_level", want.green, got.green);
          check_field("blue_level", want.blue, got.blue);
        end
      end
      outstanding <= expected_colors.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Stimulus and verdict for the depth-to-RGB565 colormap stream block.
`timescale 1ns / 1ps

module tb_top;

  localparam int PHASE_ITEMS = 175;
  localparam int HOLD_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  int mismatches;
  int outstanding;
  int send_idle_pct;
  int stall_pct;
  bit hold_go;

  // stops, their neighbors, far saturation and bit patterns
  logic [15:0] corner_depths [0:24] = '{
    16'd0,    16'd1,    16'd100,  16'd199,  16'd200,  16'd201,  16'd350,
    16'd499,  16'd500,  16'd501,  16'd750,  16'd999,  16'd1000, 16'd1001,
    16'd1500, 16'd1999, 16'd2000, 16'd2001, 16'd3000, 16'd3999, 16'd4000,
    16'd4001, 16'hFFFF, 16'h5555, 16'hAAAA
  };

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  depth_to_rgb565_colormap_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  colormap_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  task automatic send_depth(input logic [15:0] depth);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= depth;
    do @(posedge clk); while (!in_tready);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    bit held;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    int pick;
    logic [15:0] depth;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    hold_go       = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_depths[i])
      send_depth(corner_depths[i]);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  stall_pct = 0;
          hold_go = 1'b1;  // stall the output while the input keeps streaming
        end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          depth = 16'($urandom_range(3999, 1));
        end else if (pick < 82) begin
          case ($urandom_range(4))
            0: depth = 16'd200;
            1: depth = 16'd500;
            2: depth = 16'd1000;
            3: depth = 16'd2000;
            default: depth = 16'd4000;
          endcase
          depth = depth + 16'($urandom_range(4)) - 16'd2;
        end else if (pick < 94) begin
          depth = 16'($urandom_range(65535, 4000));
        end else begin
          depth = 16'($urandom_range(65535, 0));
        end
        send_depth(depth);
      end
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
